// ===== rtl/core/sliding_window_linear_predictor_assert.svh =====
// Assertion macros for the sliding window linear predictor.
`ifndef SLIDING_WINDOW_LINEAR_PREDICTOR_ASSERT_SVH
`define SLIDING_WINDOW_LINEAR_PREDICTOR_ASSERT_SVH
`ifndef ASSERT_OFF
// clocked check, disabled while reset is held
`define SWLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds during reset
`define SWLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWLP_ASSERT(lbl, clk, rstn, prop, msg)
`define SWLP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/swlp_pkg.sv =====
// Shared types and constants of the sliding window linear predictor.
`timescale 1ns / 1ps
package swlp_pkg;

  // one held sample, x in the lowest bits
  typedef struct packed {
    logic        [31:0] t;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } sample_t;

  // number of cells in the sample ring
  localparam int MAX_POINTS = 16;

  // arithmetic widths (window never exceeds 31 points)
  localparam int CNT_W = 5;
  localparam int T_W   = 24;
  localparam int ST_W  = 29;
  localparam int STT_W = 53;
  localparam int SX_W  = 21;
  localparam int STX_W = 46;
  localparam int D_W   = 58;
  localparam int NX_W  = 52;
  localparam int LV_W  = 32;
  localparam int NUM_W = 86;
  localparam int DEN_W = 63;

  localparam logic [D_W-1:0] D_MIN = D_W'(1000000);

  // outcome codes
  localparam logic [1:0] OC_EMPTY  = 2'd0;
  localparam logic [1:0] OC_SINGLE = 2'd1;
  localparam logic [1:0] OC_DEGEN  = 2'd2;
  localparam logic [1:0] OC_FIT    = 2'd3;

  // register indexes
  localparam logic REG_WIN  = 1'b0;
  localparam logic REG_LEAD = 1'b1;

  localparam logic [4:0]  WIN_RESET  = 5'd10;
  localparam logic [19:0] LEAD_RESET = 20'd16000;

endpackage

// ===== rtl/core/swlp_cell.sv =====
// One cell of the sample ring: holds a sample and passes it on when enabled.
`timescale 1ns / 1ps
module swlp_cell (
  input  logic              clk,
  input  logic              en,
  input  swlp_pkg::sample_t d,
  output swlp_pkg::sample_t q
);

  swlp_pkg::sample_t q_r;

  // sample register, no reset needed
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/core/swlp_div.sv =====
// Restoring divider: signed numerator over positive denominator, rounded and saturated.
`timescale 1ns / 1ps
module swlp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [swlp_pkg::NUM_W-1:0] num,
  input  logic [swlp_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic signed [15:0]         quot
);

  localparam int NW = swlp_pkg::NUM_W;
  localparam int DW = swlp_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          run_r, run_nxt;
  logic          fin_r, fin_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [NW-1:0] mag_r, mag_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic signed [15:0] quot_r, quot_nxt;

  logic [DW:0]   rsh;
  logic          ge;
  logic [DW:0]   rdiff;
  logic          rnd;
  logic [NW:0]   qr;

  // one quotient bit per cycle
  assign rsh   = {rem_r, mag_r[NW-1]};
  assign ge    = rsh >= {1'b0, den_r};
  assign rdiff = rsh - {1'b0, den_r};
  // round half away from zero on the magnitude
  assign rnd   = {rem_r, 1'b0} >= {1'b0, den_r};
  assign qr    = {1'b0, mag_r} + {{NW{1'b0}}, rnd};

  always_comb begin
    run_nxt  = run_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      neg_nxt = num[NW-1];
      mag_nxt = num[NW-1] ? (~num + {{(NW-1){1'b0}}, 1'b1}) : num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? rdiff[DW-1:0] : rsh[DW-1:0];
      mag_nxt = {mag_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end else if (fin_r) begin
      // saturate to the signed 16-bit integer (Q16.0) range
      if (neg_r) begin
        quot_nxt = (qr > (NW+1)'(32768)) ? 16'sh8000 : 16'(~qr[15:0] + 16'd1);
      end else begin
        quot_nxt = (qr > (NW+1)'(32767)) ? 16'sh7fff : 16'(qr[15:0]);
      end
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== rtl/core/sliding_window_linear_predictor.sv =====
// Sliding window least-squares predictor: cell ring, sum walk, fit and divide.
//
// Input words (in_*) carry a timestamped x/y sample, or a clear when in_tuser
// is set. Every input word gives exactly one result word (out_*): the position
// extrapolated lead_time_us past the newest sample, an outcome code in
// out_tuser and the number of samples held.
// A clear, or a window of one sample, goes from the result state into the
// output register. A fuller window is walked through the ring of MAX_POINTS
// cells, one cell per cycle, then products are formed by a 32-step shift-add
// unit and both coordinates go through an 86-step restoring divider. One word
// is worked on at a time; the next is taken once the previous result has
// moved into the output register.
// Reset empties the window and sets window_size to 10 and lead_time_us to
// 16000. When the receiver stalls, the result waits in the output register;
// one more word is accepted and its result is held until the register frees.
// Configuration: APB, register 0 at 0x0 (window_size), register 1 at 0x4
// (lead_time_us); write only while idle.
`timescale 1ns / 1ps
`include "sliding_window_linear_predictor_assert.svh"
module sliding_window_linear_predictor (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: sample_x[15:0], sample_y[31:16], sample_time_us[63:32]
  input  logic [63:0] in_tdata,
  // in_tuser: clear_history[0]
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: predicted_x[15:0], predicted_y[31:16], points_in_window[36:32], zero[39:37]
  output logic [39:0] out_tdata,
  // out_tuser: outcome[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAX_POINTS = swlp_pkg::MAX_POINTS;
  localparam int KW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int LW    = KW + 2;
  localparam int CNT_W = swlp_pkg::CNT_W;
  localparam int T_W   = swlp_pkg::T_W;
  localparam int ST_W  = swlp_pkg::ST_W;
  localparam int STT_W = swlp_pkg::STT_W;
  localparam int SX_W  = swlp_pkg::SX_W;
  localparam int STX_W = swlp_pkg::STX_W;
  localparam int D_W   = swlp_pkg::D_W;
  localparam int NX_W  = swlp_pkg::NX_W;
  localparam int LV_W  = swlp_pkg::LV_W;
  localparam int NUM_W = swlp_pkg::NUM_W;
  localparam int DEN_W = swlp_pkg::DEN_W;
  localparam int MW    = $clog2(LV_W);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WALK  = 9'b000000010,
    S_FLUSH = 9'b000000100,
    S_CALC1 = 9'b000001000,
    S_CALC2 = 9'b000010000,
    S_CALC3 = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration and window control
  logic [CNT_W-1:0] window_size_r, window_size_nxt;
  logic [19:0]      lead_r, lead_nxt;
  logic [CNT_W-1:0] held_count_r, held_count_nxt;

  // pending result
  logic signed [15:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [1:0]         res_outcome_r, res_outcome_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_x_r, out_y_r;
  logic [1:0]         out_outcome_r;
  logic [CNT_W-1:0]   out_points_r;

  // ring of cells
  swlp_pkg::sample_t cell_d [MAX_POINTS];
  swlp_pkg::sample_t cell_q [MAX_POINTS];
  swlp_pkg::sample_t in_sample;
  swlp_pkg::sample_t tail;
  logic              ring_en;

  // walk
  logic [KW-1:0] k_r, k_nxt;
  logic [LW-1:0] kn_sum;
  logic          in_win, first;
  logic [31:0]   t0_r, t0_nxt;
  logic [31:0]   dt;
  logic [T_W-1:0] t_sat;

  // stage after the per-sample multipliers
  logic                   a_vld_r;
  logic [T_W-1:0]         a_t_r;
  logic [2*T_W-1:0]       a_tt_r;
  logic signed [T_W+16:0] a_tx_r, a_ty_r;
  logic signed [15:0]     a_x_r, a_y_r;

  // sums
  logic [ST_W-1:0]         st_r;
  logic [STT_W-1:0]        stt_r;
  logic signed [SX_W-1:0]  sx_r, sy_r;
  logic signed [STX_W-1:0] stx_r, sty_r;
  logic [T_W-1:0]          tlast_r;

  // fit terms
  logic [D_W-1:0]          p_nstt_r, p_stst_r;
  logic signed [NX_W-1:0]  p_nstx_r, p_nsty_r, p_stsx_r, p_stsy_r;
  logic [29:0]             p_nlead_r;
  logic [24:0]             tl_sum;
  logic [D_W-1:0]          d_r;
  logic signed [NX_W-1:0]  nx_r, ny_r;
  logic signed [LV_W-1:0]  lever_r;
  logic [DEN_W-1:0]        den_r;

  // shift-add unit
  logic [NUM_W-1:0] acc_x_r, acc_y_r, mc_nx_r, mc_ny_r, mc_d_r;
  logic [LV_W-1:0]  mb_l_r, mb_x_r, mb_y_r;
  logic [MW-1:0]    m_r;
  logic             m_last;
  logic [NUM_W-1:0] term_nx, term_ny, term_dx, term_dy;

  logic             div_start_r;
  logic             div_done_x, div_done_y;
  logic signed [15:0] div_qx, div_qy;

  logic in_acc, out_free, cfg_wr;
  logic [CNT_W-1:0] win_wr;
  logic [CNT_W-1:0] held_inc;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_tready = (state_r == S_IDLE);
  assign held_inc = (held_count_r < window_size_r) ? held_count_r + CNT_W'(1) : held_count_r;

  // clamp a window size write to [2, MAX_POINTS]
  always_comb begin
    win_wr = cfg_pwdata[CNT_W-1:0];
    if (win_wr < CNT_W'(2)) begin
      win_wr = CNT_W'(2);
    end else if (int'(win_wr) > MAX_POINTS) begin
      win_wr = CNT_W'(MAX_POINTS);
    end
  end

  // cell ring: load shifts a new sample in, walk rotates the tail to the head
  assign in_sample = swlp_pkg::sample_t'(in_tdata);
  assign tail      = cell_q[MAX_POINTS-1];
  assign ring_en   = (in_acc && !in_tuser[0]) || (state_r == S_WALK);
  assign cell_d[0] = (state_r == S_WALK) ? tail : in_sample;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_d[i] = cell_q[i-1];
    end
    swlp_cell u_cell (
      .clk (clk),
      .en  (ring_en),
      .d   (cell_d[i]),
      .q   (cell_q[i])
    );
  end

  // tail position k holds window entry MAX_POINTS-1-k; oldest comes first
  assign kn_sum = LW'(k_r) + LW'(held_count_r);
  assign in_win = (state_r == S_WALK) && (kn_sum >= LW'(MAX_POINTS));
  assign first  = (kn_sum == LW'(MAX_POINTS));
  assign t0_nxt = (in_win && first) ? tail.t : t0_r;
  assign dt     = tail.t - (first ? tail.t : t0_r);
  assign t_sat  = (|dt[31:T_W]) ? {T_W{1'b1}} : dt[T_W-1:0];

  // per-sample products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_win;
    end
  end

  always_ff @(posedge clk) begin
    t0_r   <= t0_nxt;
    a_t_r  <= t_sat;
    a_tt_r <= t_sat * t_sat;
    a_tx_r <= $signed({1'b0, t_sat}) * tail.x;
    a_ty_r <= $signed({1'b0, t_sat}) * tail.y;
    a_x_r  <= tail.x;
    a_y_r  <= tail.y;
  end

  // running sums over the window
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_r  <= '0;
      stt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      stx_r <= '0;
      sty_r <= '0;
    end else if (a_vld_r) begin
      st_r    <= st_r + ST_W'(a_t_r);
      stt_r   <= stt_r + STT_W'(a_tt_r);
      sx_r    <= sx_r + SX_W'(a_x_r);
      sy_r    <= sy_r + SX_W'(a_y_r);
      stx_r   <= stx_r + STX_W'(a_tx_r);
      sty_r   <= sty_r + STX_W'(a_ty_r);
      tlast_r <= a_t_r;
    end
  end

  // fit terms, one multiplier level per stage
  assign tl_sum = {1'b0, tlast_r} + {5'b0, lead_r};

  always_ff @(posedge clk) begin
    if (state_r == S_CALC1) begin
      p_nstt_r  <= held_count_r * stt_r;
      p_stst_r  <= st_r * st_r;
      p_nstx_r  <= $signed({1'b0, held_count_r}) * stx_r;
      p_nsty_r  <= $signed({1'b0, held_count_r}) * sty_r;
      p_stsx_r  <= $signed({1'b0, st_r}) * sx_r;
      p_stsy_r  <= $signed({1'b0, st_r}) * sy_r;
      p_nlead_r <= held_count_r * tl_sum;
    end
    if (state_r == S_CALC2) begin
      d_r     <= p_nstt_r - p_stst_r;
      nx_r    <= p_nstx_r - p_stsx_r;
      ny_r    <= p_nsty_r - p_stsy_r;
      lever_r <= $signed({2'b0, p_nlead_r}) - $signed({3'b0, st_r});
    end
    if (state_r == S_CALC3) begin
      den_r <= held_count_r * d_r;
    end
  end

  // shift-add: num = S*D + N*lever, top multiplier bit weighs negative
  assign m_last  = (m_r == MW'(LV_W - 1));
  assign term_nx = mb_l_r[0] ? (m_last ? (~mc_nx_r + 1'b1) : mc_nx_r) : '0;
  assign term_ny = mb_l_r[0] ? (m_last ? (~mc_ny_r + 1'b1) : mc_ny_r) : '0;
  assign term_dx = mb_x_r[0] ? (m_last ? (~mc_d_r + 1'b1) : mc_d_r) : '0;
  assign term_dy = mb_y_r[0] ? (m_last ? (~mc_d_r + 1'b1) : mc_d_r) : '0;

  always_ff @(posedge clk) begin
    if (state_r == S_CALC3) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      mc_nx_r <= {{(NUM_W-NX_W){nx_r[NX_W-1]}}, nx_r};
      mc_ny_r <= {{(NUM_W-NX_W){ny_r[NX_W-1]}}, ny_r};
      mc_d_r  <= {{(NUM_W-D_W){1'b0}}, d_r};
      mb_l_r  <= lever_r;
      mb_x_r  <= {{(LV_W-SX_W){sx_r[SX_W-1]}}, sx_r};
      mb_y_r  <= {{(LV_W-SX_W){sy_r[SX_W-1]}}, sy_r};
      m_r     <= '0;
    end else if (state_r == S_MUL) begin
      acc_x_r <= acc_x_r + term_nx + term_dx;
      acc_y_r <= acc_y_r + term_ny + term_dy;
      mc_nx_r <= {mc_nx_r[NUM_W-2:0], 1'b0};
      mc_ny_r <= {mc_ny_r[NUM_W-2:0], 1'b0};
      mc_d_r  <= {mc_d_r[NUM_W-2:0], 1'b0};
      mb_l_r  <= {1'b0, mb_l_r[LV_W-1:1]};
      mb_x_r  <= {1'b0, mb_x_r[LV_W-1:1]};
      mb_y_r  <= {1'b0, mb_y_r[LV_W-1:1]};
      m_r     <= m_r + MW'(1);
    end
  end

  // dividers, x and y in lockstep
  swlp_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (acc_x_r),
    .den   (den_r),
    .done  (div_done_x),
    .quot  (div_qx)
  );

  swlp_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (acc_y_r),
    .den   (den_r),
    .done  (div_done_y),
    .quot  (div_qy)
  );

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    window_size_nxt = window_size_r;
    lead_nxt        = lead_r;
    held_count_nxt  = held_count_r;
    res_x_nxt       = res_x_r;
    res_y_nxt       = res_y_r;
    res_outcome_nxt = res_outcome_r;
    out_valid_nxt   = out_valid_r;
    k_nxt           = k_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr) begin
      if (cfg_paddr[2] == swlp_pkg::REG_WIN) begin
        window_size_nxt = win_wr;
        if (held_count_r > win_wr) begin
          held_count_nxt = win_wr;
        end
      end else begin
        lead_nxt = cfg_pwdata[19:0];
      end
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          k_nxt = '0;
          if (in_tuser[0]) begin
            held_count_nxt  = '0;
            res_x_nxt       = '0;
            res_y_nxt       = '0;
            res_outcome_nxt = swlp_pkg::OC_EMPTY;
            state_nxt       = S_DONE;
          end else begin
            held_count_nxt  = held_inc;
            res_x_nxt       = in_sample.x;
            res_y_nxt       = in_sample.y;
            res_outcome_nxt = swlp_pkg::OC_SINGLE;
            state_nxt       = (held_inc >= CNT_W'(2)) ? S_WALK : S_DONE;
          end
        end
      end
      S_WALK: begin
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(MAX_POINTS - 1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: state_nxt = S_CALC1;
      S_CALC1: state_nxt = S_CALC2;
      S_CALC2: state_nxt = S_CALC3;
      S_CALC3: begin
        if (d_r <= swlp_pkg::D_MIN) begin
          res_outcome_nxt = swlp_pkg::OC_DEGEN;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (m_last) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done_x && div_done_y) begin
          res_x_nxt       = div_qx;
          res_y_nxt       = div_qy;
          res_outcome_nxt = swlp_pkg::OC_FIT;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      window_size_r <= swlp_pkg::WIN_RESET;
      lead_r        <= swlp_pkg::LEAD_RESET;
      held_count_r  <= '0;
      out_valid_r   <= 1'b0;
      div_start_r   <= 1'b0;
      k_r           <= '0;
    end else begin
      state_r       <= state_nxt;
      window_size_r <= window_size_nxt;
      lead_r        <= lead_nxt;
      held_count_r  <= held_count_nxt;
      out_valid_r   <= out_valid_nxt;
      div_start_r   <= (state_r == S_MUL) && m_last;
      k_r           <= k_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_x_r       <= res_x_nxt;
    res_y_r       <= res_y_nxt;
    res_outcome_r <= res_outcome_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_x_r       <= res_x_r;
      out_y_r       <= res_y_r;
      out_outcome_r <= res_outcome_r;
      out_points_r  <= held_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_points_r, out_y_r, out_x_r};
  assign out_tuser  = out_outcome_r;

  // register readback
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == swlp_pkg::REG_LEAD) ? {12'b0, lead_r}
                                                           : {27'b0, window_size_r};

  `SWLP_ASSERT(a_held_in_window, clk, rst_n, held_count_r <= window_size_r,
               "held count above window size")
  `SWLP_ASSERT(a_clear_empties, clk, rst_n, (in_acc && in_tuser[0]) |=>
               (res_outcome_r == swlp_pkg::OC_EMPTY && held_count_r == '0),
               "clear did not empty the window")
  `SWLP_ASSERT(a_fit_needs_two, clk, rst_n,
               (out_valid_r && out_outcome_r == swlp_pkg::OC_FIT) |-> (out_points_r >= CNT_W'(2)),
               "fitted result with fewer than two points")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the sliding window linear predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int SLOTS = swlp_pkg::MAX_POINTS;

  // Tracks the sample window and the queue of predictions still owed.
  class fit_scoreboard;
    logic [63:0] ring[SLOTS];
    int unsigned held;
    int unsigned head;
    int unsigned win_len;
    int unsigned lead_us;
    logic [41:0] owed[$];   // {pad, outcome, points, y, x}
    int unsigned mismatches;
    int unsigned checked;

    function void reset_state();
      held = 0;
      head = 0;
      win_len = swlp_pkg::WIN_RESET;
      lead_us = swlp_pkg::LEAD_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      int unsigned w;
      if (idx == swlp_pkg::REG_WIN) begin
        w = value[4:0];
        if (w < 2) w = 2;
        if (w > SLOTS) w = SLOTS;
        win_len = w;
        if (held > win_len) held = win_len;
      end else begin
        lead_us = value[19:0];
      end
    endfunction

    // rounded, saturated quotient of a signed value over a positive one
    function logic [15:0] round_div(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] mag, q, r;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      r = mag - q * den;
      if (2 * r >= den) q = q + 1;
      if (num < 0) return (q > 32768) ? 16'h8000 : 16'(-q);
      return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    // work out the prediction caused by one accepted word
    function void note_word(logic clear, logic [63:0] data);
      logic [15:0] px, py;
      logic [1:0] oc;
      logic [31:0] t0, dt;
      logic [63:0] e;
      logic signed [127:0] n, tw, xw, yw, st, stt, sx, sy, stx, sty, tlast, d, nxv, nyv, lever;
      int unsigned oldest;
      logic [41:0] item;
      px = 0;
      py = 0;
      oc = swlp_pkg::OC_EMPTY;
      if (clear) begin
        held = 0;
      end else begin
        head = (head + 1) % SLOTS;
        ring[head] = data;
        if (held < win_len) held++;
      end
      if (held >= 1) begin
        px = ring[head][15:0];
        py = ring[head][31:16];
        oc = swlp_pkg::OC_SINGLE;
      end
      if (held >= 2) begin
        n = held;
        oldest = (head + SLOTS - (held - 1)) % SLOTS;
        t0 = ring[oldest][63:32];
        st = 0; stt = 0; sx = 0; sy = 0; stx = 0; sty = 0; tlast = 0;
        for (int k = 0; k < held; k++) begin
          e = ring[(oldest + k) % SLOTS];
          dt = e[63:32] - t0;
          tw = (dt > 32'hffffff) ? 32'hffffff : dt;
          xw = $signed(e[15:0]);
          yw = $signed(e[31:16]);
          st += tw;
          stt += tw * tw;
          sx += xw;
          sy += yw;
          stx += tw * xw;
          sty += tw * yw;
          tlast = tw;
        end
        d = n * stt - st * st;
        if (d <= 1000000) begin
          oc = swlp_pkg::OC_DEGEN;
        end else begin
          nxv = n * stx - st * sx;
          nyv = n * sty - st * sy;
          tw = lead_us;
          lever = n * (tlast + tw) - st;
          px = round_div(sx * d + nxv * lever, n * d);
          py = round_div(sy * d + nyv * lever, n * d);
          oc = swlp_pkg::OC_FIT;
        end
      end
      item = {3'b000, oc, 5'(held), py, px};
      owed = {owed, item};
    endfunction

    function void check_result(logic [39:0] data, logic [1:0] oc);
      logic [41:0] want, got;
      got = {data[39:37], oc, data[36:0]};
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = owed[0];
      owed.delete(0);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: x %h/%h y %h/%h points %0d/%0d outcome %0d/%0d pad %0d/%0d",
                   checked, want[15:0], got[15:0], want[31:16], got[31:16],
                   want[36:32], got[36:32], want[38:37], got[38:37], want[41:39], got[41:39]);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic [63:0] in_tdata = 0;
  logic [0:0]  in_tuser = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fit_scoreboard sb;
  bit          no_gaps = 0;     // stretch with no idling on either side
  bit          hold_req = 0;    // asks the receiver for a long hold-off
  int unsigned words_sent = 0;
  int unsigned cfg_writes = 0;
  logic [31:0] clock_us = 0;
  logic signed [15:0] pos_x = 0, pos_y = 0;

  sliding_window_linear_predictor uut (.*);

  always #1 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 3000;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 0;
      end else begin
        out_tready <= no_gaps || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic send_word(logic clear, logic [15:0] x, logic [15:0] y, logic [31:0] t);
    if (!no_gaps && $urandom_range(99) < 27) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= clear;
    in_tdata <= {t, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(clear, {t, y, x});
    words_sent++;
  endtask

  // register write once every owed result has arrived
  task automatic write_reg(logic idx, logic [31:0] value);
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.set_reg(idx, value);
    cfg_writes++;
  endtask

  // next sample along a moving track, with occasional clears, odd timing and jumps
  task automatic send_track_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_word(1, 16'($urandom), 16'($urandom), $urandom);
      return;
    end
    if (pick < 12) clock_us = clock_us + $urandom_range(0, 400);
    else if (pick < 16) clock_us = $urandom;
    else clock_us = clock_us + $urandom_range(1000, 60000);
    if ($urandom_range(99) < 10) begin
      pos_x = 16'($urandom);
      pos_y = 16'($urandom);
    end else begin
      pos_x = pos_x + $signed(11'($urandom)) ;
      pos_y = pos_y + $signed(11'($urandom));
    end
    send_word(0, pos_x, pos_y, clock_us);
  endtask

  initial begin
    logic [31:0] win_vals[8];
    sb = new();
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty, single, degenerate, fitted, extremes, wrap, saturation
    send_word(1, 16'hffff, 16'hffff, 32'hffffffff);
    send_word(0, 16'h8000, 16'h7fff, 32'h0);
    send_word(0, 16'h7fff, 16'h8000, 32'h0);
    send_word(0, 16'h7fff, 16'h8000, 32'd16000);
    send_word(0, 16'h8000, 16'h7fff, 32'd32000);
    send_word(1, 0, 0, 0);
    send_word(0, 16'h0010, 16'hfff0, 32'hffffc000);
    send_word(0, 16'h0020, 16'hffe0, 32'h00002000);
    send_word(0, 16'h0030, 16'hffd0, 32'h0000a000);
    send_word(0, 16'h0040, 16'hffc0, 32'h7fffffff);
    write_reg(swlp_pkg::REG_LEAD, 32'hfff_fffff);
    send_word(0, 16'h7fff, 16'h8000, 32'h80000000);
    send_word(1, 0, 0, 0);
    send_word(0, 16'h8000, 16'h7fff, 32'd100);
    send_word(0, 16'h7fff, 16'h8000, 32'd200000);
    write_reg(swlp_pkg::REG_LEAD, 32'd0);
    send_word(0, 16'h0000, 16'h0000, 32'd400000);
    write_reg(swlp_pkg::REG_WIN, 32'd0);
    send_word(0, 16'h1234, 16'hedcb, 32'd420000);
    write_reg(swlp_pkg::REG_WIN, 32'd31);
    for (int i = 0; i < 6; i++) send_word(0, 16'(i * 300), 16'(-i * 200), 32'(450000 + i * 9000));

    // random phases over several window and lead settings
    win_vals = '{32'd1, 32'd16, 32'd2, 32'd17, 32'hffffffe5, 32'd3, 32'd10, 32'd8};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(swlp_pkg::REG_WIN, win_vals[ph]);
      write_reg(swlp_pkg::REG_LEAD, (ph == 1) ? 32'd1000000 : (ph == 4) ? 32'd0 : $urandom);
      if (ph == 2) hold_req = 1;
      no_gaps = (ph == 5);
      for (int i = 0; i < 104; i++) send_track_sample();
    end
    no_gaps = 0;

    // drain and let the block settle
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d words, %0d results checked, %0d register writes",
             words_sent, sb.checked, cfg_writes);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/swlp_pkg.sv
rtl/core/swlp_cell.sv
rtl/core/swlp_div.sv
rtl/core/sliding_window_linear_predictor.sv
test/tb_top.sv
